/* rtl/rurt_pkg.sv */
// Shared types and codes of the receive tracker.
`timescale 1ns / 1ps

package rurt_pkg;

  localparam int SEQ_W   = 11;
  localparam int TS_W    = 32;
  localparam int SLOT_W  = 5;
  localparam int CNT_W   = 5;
  localparam int KIND_W  = 2;
  localparam int CMD_W   = 2;

  // Packet types on the command input
  localparam logic [CMD_W-1:0] CMD_DATA = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FIN  = 2'd1;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_ACK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOST = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ALL  = 2'd2;

  // Classified operation carried from the front to the back
  typedef enum logic [1:0] {
    OP_DATA,
    OP_BAD,
    OP_FIN
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [SEQ_W-1:0]  seq;
    logic [SEQ_W-1:0]  total;
    logic [TS_W-1:0]   timestamp;
    logic [SLOT_W-1:0] slot;
    logic [SEQ_W-1:0]  window;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } queue_out_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

/* rtl/rurt_front.sv */
// Front end: accepts packet headers, saturates the total and classifies them.
`timescale 1ns / 1ps

module rurt_front #(
  parameter int MAX_PACKETS = 1024
) (
  input  logic                                  start,
  output logic                                  busy,
  input  logic [rurt_pkg::CMD_W-1:0]            command_i,
  input  logic [rurt_pkg::SEQ_W-1:0]            seq_i,
  input  logic [rurt_pkg::SEQ_W-1:0]            total_i,
  input  logic [rurt_pkg::TS_W-1:0]             timestamp_i,
  input  logic [rurt_pkg::SLOT_W-1:0]           slot_i,
  input  logic [rurt_pkg::SEQ_W-1:0]            window_i,
  input  logic                                  q_full_i,
  input  rurt_pkg::back_status_t                status_i,
  output logic                                  push_o,
  output rurt_pkg::entry_t                      entry_o
);

  logic [rurt_pkg::SEQ_W-1:0] total_sat;
  logic                       seq_bad;

  assign busy = q_full_i | status_i.clearing;

  always_comb begin
    if (32'(total_i) > MAX_PACKETS) begin
      total_sat = rurt_pkg::SEQ_W'(MAX_PACKETS);
    end else begin
      total_sat = total_i;
    end
    seq_bad = (seq_i == '0) || (seq_i > total_sat);
  end

  always_comb begin
    entry_o.seq       = seq_i;
    entry_o.total     = total_sat;
    entry_o.timestamp = timestamp_i;
    entry_o.slot      = slot_i;
    entry_o.window    = window_i;
    if (command_i == rurt_pkg::CMD_FIN) begin
      entry_o.op = rurt_pkg::OP_FIN;
    end else if (seq_bad) begin
      entry_o.op = rurt_pkg::OP_BAD;
    end else begin
      entry_o.op = rurt_pkg::OP_DATA;
    end
  end

  // Drop unknown commands: they are accepted but never queued
  assign push_o = start & ~busy &
                  ((command_i == rurt_pkg::CMD_DATA) || (command_i == rurt_pkg::CMD_FIN));

endmodule

/* rtl/rurt_queue.sv */
// Two-entry queue of classified words between the front and the back.
`timescale 1ns / 1ps

module rurt_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  rurt_pkg::entry_t     entry_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output rurt_pkg::queue_out_t q_o
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  rurt_pkg::entry_t  slots_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [PW:0]       count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == (PW+1)'(DEPTH));
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & (count_q != '0);

  assign q_o.valid = (count_q != '0);
  assign q_o.entry = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

/* rtl/rurt_back.sv */
// Back end: received bitmap, acknowledge generation and fin scan.
`timescale 1ns / 1ps

module rurt_back #(
  parameter int MAX_PACKETS = 1024,
  parameter int MAX_LOST    = 20
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rurt_pkg::queue_out_t            q_i,
  output logic                            pop_o,
  output rurt_pkg::back_status_t          status_o,
  output logic                            ack_valid_o,
  output logic [rurt_pkg::KIND_W-1:0]     ack_kind_o,
  output logic [rurt_pkg::SLOT_W-1:0]     ack_slot_o,
  output logic [rurt_pkg::SEQ_W-1:0]      ack_seq_o,
  output logic [rurt_pkg::TS_W-1:0]       ack_timestamp_o,
  output logic [rurt_pkg::CNT_W-1:0]      ack_count_o,
  output logic [rurt_pkg::SEQ_W-1:0]      ack_window_o,
  output logic                            duplicate_o,
  output logic                            bad_seq_o,
  output logic                            last_o
);

  localparam int AW = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
  localparam int WW = (AW > rurt_pkg::SEQ_W) ? AW : rurt_pkg::SEQ_W;
  localparam int NW = $clog2(MAX_LOST + 1);
  localparam int SW = rurt_pkg::SEQ_W;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DCHK  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_FEND  = 3'd4;

  function automatic logic [AW-1:0] to_addr(input logic [SW-1:0] v);
    logic [WW-1:0] w;
    w = WW'(v);
    return w[AW-1:0];
  endfunction

  // Bitmap memory
  logic          mem [MAX_PACKETS];
  logic          rd_en, wr_en, wr_data, rd_data_q;
  logic [AW-1:0] rd_addr, wr_addr;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;
  logic [SW-1:0] total_count_q, total_count_d;

  // Data packet held across the read-modify-write
  logic [AW-1:0]                 cur_addr_q, cur_addr_d;
  logic [SW-1:0]                 cur_seq_q, cur_seq_d;
  logic [rurt_pkg::TS_W-1:0]     cur_ts_q, cur_ts_d;
  logic [rurt_pkg::SLOT_W-1:0]   cur_slot_q, cur_slot_d;
  logic [SW-1:0]                 cur_win_q, cur_win_d;

  // Fin scan
  logic [SW-1:0]                 iss_q, iss_d;
  logic                          chk_v_q, chk_v_d;
  logic [SW-1:0]                 chk_idx_q, chk_idx_d;
  logic [NW-1:0]                 lost_n_q, lost_n_d;
  logic [NW-1:0]                 lost_inc;
  logic                          pend_v_q, pend_v_d;
  logic [SW-1:0]                 pend_seq_q, pend_seq_d;
  logic [rurt_pkg::CNT_W-1:0]    pend_cnt_q, pend_cnt_d;

  // Result to register
  logic                          emit;
  logic [rurt_pkg::KIND_W-1:0]   e_kind;
  logic [rurt_pkg::SLOT_W-1:0]   e_slot;
  logic [SW-1:0]                 e_seq;
  logic [rurt_pkg::TS_W-1:0]     e_ts;
  logic [rurt_pkg::CNT_W-1:0]    e_cnt;
  logic [SW-1:0]                 e_win;
  logic                          e_dup, e_bad, e_last;

  logic                          out_valid_q;

  assign status_o.clearing = (state_q == ST_CLEAR);
  assign lost_inc          = lost_n_q + 1'b1;

  always_comb begin
    state_d       = state_q;
    clr_addr_d    = clr_addr_q;
    total_count_d = total_count_q;
    cur_addr_d    = cur_addr_q;
    cur_seq_d     = cur_seq_q;
    cur_ts_d      = cur_ts_q;
    cur_slot_d    = cur_slot_q;
    cur_win_d     = cur_win_q;
    iss_d         = iss_q;
    chk_v_d       = 1'b0;
    chk_idx_d     = chk_idx_q;
    lost_n_d      = lost_n_q;
    pend_v_d      = pend_v_q;
    pend_seq_d    = pend_seq_q;
    pend_cnt_d    = pend_cnt_q;
    pop_o         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = cur_addr_q;
    wr_data       = 1'b1;
    emit          = 1'b0;
    e_kind        = rurt_pkg::KIND_ACK;
    e_slot        = '0;
    e_seq         = '0;
    e_ts          = '0;
    e_cnt         = '0;
    e_win         = '0;
    e_dup         = 1'b0;
    e_bad         = 1'b0;
    e_last        = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr_q;
        wr_data = 1'b0;
        if (clr_addr_q == AW'(MAX_PACKETS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_addr_d = clr_addr_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (q_i.valid) begin
          pop_o = 1'b1;
          case (q_i.entry.op)
            rurt_pkg::OP_DATA: begin
              total_count_d = q_i.entry.total;
              rd_en         = 1'b1;
              rd_addr       = to_addr(q_i.entry.seq - 1'b1);
              cur_addr_d    = to_addr(q_i.entry.seq - 1'b1);
              cur_seq_d     = q_i.entry.seq;
              cur_ts_d      = q_i.entry.timestamp;
              cur_slot_d    = q_i.entry.slot;
              cur_win_d     = q_i.entry.window;
              state_d       = ST_DCHK;
            end
            rurt_pkg::OP_BAD: begin
              // Out-of-range number: acknowledge without touching the map
              total_count_d = q_i.entry.total;
              emit          = 1'b1;
              e_slot        = q_i.entry.slot;
              e_seq         = q_i.entry.seq;
              e_ts          = q_i.entry.timestamp;
              e_cnt         = q_i.entry.slot + 1'b1;
              e_win         = q_i.entry.window;
              e_bad         = 1'b1;
              e_last        = 1'b1;
            end
            rurt_pkg::OP_FIN: begin
              iss_d    = '0;
              lost_n_d = '0;
              pend_v_d = 1'b0;
              state_d  = ST_SCAN;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_DCHK: begin
        // Mark the number unless the read shows it already set
        wr_en   = ~rd_data_q;
        emit    = 1'b1;
        e_slot  = cur_slot_q;
        e_seq   = cur_seq_q;
        e_ts    = cur_ts_q;
        e_cnt   = cur_slot_q + 1'b1;
        e_win   = cur_win_q;
        e_dup   = rd_data_q;
        e_last  = 1'b1;
        state_d = ST_IDLE;
      end

      ST_SCAN: begin
        if (iss_q < total_count_q) begin
          rd_en     = 1'b1;
          rd_addr   = to_addr(iss_q);
          chk_v_d   = 1'b1;
          chk_idx_d = iss_q;
          iss_d     = iss_q + 1'b1;
        end
        if (chk_v_q && !rd_data_q) begin
          // Flush the previous lost number, hold this one until the next or the end
          if (pend_v_q) begin
            emit   = 1'b1;
            e_kind = rurt_pkg::KIND_LOST;
            e_seq  = pend_seq_q;
            e_cnt  = pend_cnt_q;
          end
          pend_v_d   = 1'b1;
          pend_seq_d = chk_idx_q + 1'b1;
          pend_cnt_d = rurt_pkg::CNT_W'(lost_inc);
          lost_n_d   = lost_inc;
          if (lost_inc == NW'(MAX_LOST)) begin
            chk_v_d = 1'b0;
            state_d = ST_FEND;
          end
        end else if (!chk_v_q && !(iss_q < total_count_q)) begin
          state_d = ST_FEND;
        end
      end

      ST_FEND: begin
        emit   = 1'b1;
        e_last = 1'b1;
        if (pend_v_q) begin
          e_kind = rurt_pkg::KIND_LOST;
          e_seq  = pend_seq_q;
          e_cnt  = pend_cnt_q;
        end else begin
          e_kind = rurt_pkg::KIND_ALL;
        end
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_addr_q    <= '0;
      total_count_q <= '0;
      chk_v_q       <= 1'b0;
      lost_n_q      <= '0;
      pend_v_q      <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      clr_addr_q    <= clr_addr_d;
      total_count_q <= total_count_d;
      chk_v_q       <= chk_v_d;
      lost_n_q      <= lost_n_d;
      pend_v_q      <= pend_v_d;
      out_valid_q   <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_addr_q      <= cur_addr_d;
    cur_seq_q       <= cur_seq_d;
    cur_ts_q        <= cur_ts_d;
    cur_slot_q      <= cur_slot_d;
    cur_win_q       <= cur_win_d;
    iss_q           <= iss_d;
    chk_idx_q       <= chk_idx_d;
    pend_seq_q      <= pend_seq_d;
    pend_cnt_q      <= pend_cnt_d;
    ack_kind_o      <= e_kind;
    ack_slot_o      <= e_slot;
    ack_seq_o       <= e_seq;
    ack_timestamp_o <= e_ts;
    ack_count_o     <= e_cnt;
    ack_window_o    <= e_win;
    duplicate_o     <= e_dup;
    bad_seq_o       <= e_bad;
    last_o          <= e_last;
  end

  assign ack_valid_o = out_valid_q;

  a_no_mark_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !wr_en)
    else $error("bitmap written during fin scan");

  a_lost_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lost_n_q <= NW'(MAX_LOST))
    else $error("lost report count beyond limit");

  a_all_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (ack_kind_o == rurt_pkg::KIND_ALL)) |-> last_o)
    else $error("all-received result without last");

  a_check_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DCHK) |-> ($past(state_q) == ST_IDLE && $past(pop_o)))
    else $error("data check without a popped word");

endmodule

/* rtl/reliable_udp_receive_tracker.sv */
// Top level of the selective-repeat receive tracker.
//
// Usage: drive a packet header on command_i and its fields and raise start;
// the word is taken at a rising edge with start high and busy low. Results
// leave on the ack_* ports for one cycle each, marked by ack_valid_o; the
// receiver cannot hold them off, and last_o flags the final result of a header.
// A front classifies headers (data, bad data, fin, or dropped) into a
// two-entry queue; a back unit owns the received bitmap (one bit per packet,
// one read and one write port) and produces results.
// Data path: with the back unit idle, an acknowledge passes the queue slot,
// the bitmap read register and the output registers; a bad number skips the read.
// Order of work: a data header pops with a bitmap read, then is checked and
// marked; a header with a bad number is answered at the pop; a fin pops, makes
// one bitmap read per cycle, finishes the last check and then gives the final
// word, stopping early after MAX_LOST lost numbers. Unknown commands are taken
// and give nothing.
// busy rises when the queue is full.
// Reset: the bitmap is cleared by a pass over all MAX_PACKETS entries, one entry per
// cycle, with busy high throughout; the stored total resets to zero.
`timescale 1ns / 1ps

module reliable_udp_receive_tracker #(
  parameter int MAX_PACKETS = 1024,
  parameter int MAX_LOST    = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [rurt_pkg::CMD_W-1:0]     command_i,
  input  logic [rurt_pkg::SEQ_W-1:0]     seq_i,
  input  logic [rurt_pkg::SEQ_W-1:0]     total_i,
  input  logic [rurt_pkg::TS_W-1:0]      timestamp_i,
  input  logic [rurt_pkg::SLOT_W-1:0]    slot_i,
  input  logic [rurt_pkg::SEQ_W-1:0]     window_i,
  output logic                           ack_valid_o,
  output logic [rurt_pkg::KIND_W-1:0]    ack_kind_o,
  output logic [rurt_pkg::SLOT_W-1:0]    ack_slot_o,
  output logic [rurt_pkg::SEQ_W-1:0]     ack_seq_o,
  output logic [rurt_pkg::TS_W-1:0]      ack_timestamp_o,
  output logic [rurt_pkg::CNT_W-1:0]     ack_count_o,
  output logic [rurt_pkg::SEQ_W-1:0]     ack_window_o,
  output logic                           duplicate_o,
  output logic                           bad_seq_o,
  output logic                           last_o
);

  logic                   push, q_full, pop;
  rurt_pkg::entry_t       entry;
  rurt_pkg::queue_out_t   q_out;
  rurt_pkg::back_status_t status;

  rurt_front #(
    .MAX_PACKETS(MAX_PACKETS)
  ) u_front (
    .start       (start),
    .busy        (busy),
    .command_i   (command_i),
    .seq_i       (seq_i),
    .total_i     (total_i),
    .timestamp_i (timestamp_i),
    .slot_i      (slot_i),
    .window_i    (window_i),
    .q_full_i    (q_full),
    .status_i    (status),
    .push_o      (push),
    .entry_o     (entry)
  );

  rurt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .q_o     (q_out)
  );

  rurt_back #(
    .MAX_PACKETS(MAX_PACKETS),
    .MAX_LOST   (MAX_LOST)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_i             (q_out),
    .pop_o           (pop),
    .status_o        (status),
    .ack_valid_o     (ack_valid_o),
    .ack_kind_o      (ack_kind_o),
    .ack_slot_o      (ack_slot_o),
    .ack_seq_o       (ack_seq_o),
    .ack_timestamp_o (ack_timestamp_o),
    .ack_count_o     (ack_count_o),
    .ack_window_o    (ack_window_o),
    .duplicate_o     (duplicate_o),
    .bad_seq_o       (bad_seq_o),
    .last_o          (last_o)
  );

endmodule
